[rtl/dspm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package dspm_pkg;

    // Pattern characters with a special meaning
    localparam logic [7:0] STAR_CHAR = 8'h2A;
    localparam logic [7:0] DOT_CHAR  = 8'h2E;

    // Characters the two pattern registers can hold
    localparam int REG_CHARS = 16;

    // Width of the pattern length register
    localparam int LEN_W = 5;

    // Item mode codes
    localparam logic MODE_START   = 1'b0;
    localparam logic MODE_CONSUME = 1'b1;

    // Register indexes (byte address / 8)
    localparam logic [1:0] REG_PAT_LOW  = 2'd0;
    localparam logic [1:0] REG_PAT_HIGH = 2'd1;
    localparam logic [1:0] REG_PAT_LEN  = 2'd2;

    // One input item as it moves between the stages
    typedef struct packed {
        logic       mode;
        logic [7:0] text_char;
    } t_item;

endpackage

`default_nettype wire

[rtl/dspm_row_next.sv]
`timescale 1ns / 1ps
`default_nettype none

module dspm_row_next #(
    parameter int MAX_PATTERN = 16
) (
    input  wire logic [MAX_PATTERN:0]       i_row,
    input  wire dspm_pkg::t_item            i_item,
    input  wire logic [63:0]                i_pat_low,
    input  wire logic [63:0]                i_pat_high,
    input  wire logic [dspm_pkg::LEN_W-1:0] i_pat_len,
    output logic      [MAX_PATTERN:0]       o_row,
    output logic                            o_match
);

    localparam int CAP = (MAX_PATTERN < dspm_pkg::REG_CHARS) ?
                         MAX_PATTERN : dspm_pkg::REG_CHARS;
    localparam int IDX_W = (MAX_PATTERN > 0) ? $clog2(MAX_PATTERN + 1) : 1;

    logic [127:0]               w_all;
    logic [7:0]                 w_pat [MAX_PATTERN];
    logic [dspm_pkg::LEN_W-1:0] w_active;
    logic                       w_start;

    // Pattern character against text character
    function automatic logic char_hits(input logic [7:0] pc, input logic [7:0] tc);
        return (pc == dspm_pkg::DOT_CHAR) || (pc == tc);
    endfunction

    // Unpack pattern characters; positions past the registers read as zero
    assign w_all = {i_pat_high, i_pat_low};

    always_comb begin
        for (int k = 0; k < MAX_PATTERN; k++) begin
            if (k < dspm_pkg::REG_CHARS) begin
                w_pat[k] = w_all[8*(k % dspm_pkg::REG_CHARS) +: 8];
            end else begin
                w_pat[k] = 8'h00;
            end
        end
    end

    // Clamp the length to the columns that exist
    assign w_active = (i_pat_len > dspm_pkg::LEN_W'(CAP)) ?
                      dspm_pkg::LEN_W'(CAP) : i_pat_len;
    assign w_start  = (i_item.mode == dspm_pkg::MODE_START);

    // Build the next row; columns past the active length stay clear
    always_comb begin
        o_row    = '0;
        o_row[0] = w_start;
        // A star in the first position has no element and never matches
        o_row[1] = (w_active != '0) && !w_start &&
                   (w_pat[0] != dspm_pkg::STAR_CHAR) &&
                   i_row[0] && char_hits(w_pat[0], i_item.text_char);
        for (int j = 2; j <= MAX_PATTERN; j++) begin
            if (j <= int'(w_active)) begin
                if (w_pat[j-1] != dspm_pkg::STAR_CHAR) begin
                    o_row[j] = !w_start && i_row[j-1] &&
                               char_hits(w_pat[j-1], i_item.text_char);
                end else if (w_start) begin
                    o_row[j] = o_row[j-2];
                end else begin
                    o_row[j] = o_row[j-2] ||
                               (char_hits(w_pat[j-2], i_item.text_char) && i_row[j]);
                end
            end
        end
    end

    // Whole-pattern column
    assign o_match = o_row[IDX_W'(w_active)];

endmodule

`default_nettype wire

[rtl/dot_star_pattern_matcher_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel    Direction  Handshake                      Content
// s_axis     in         s_axis_tvalid / s_axis_tready  tdata: text_char; tuser: mode
// m_axis     out        m_axis_tvalid / m_axis_tready  tdata[0]: prefix_matches
// apb        in         psel, penable, pwrite, pready  pattern low/high at 0x00/0x08,
//                                                      length at 0x10
//
// One transaction per cycle in, one result per cycle out unless the output stalls.
// The match row update from the input register to the result register sets the
// cycle: it is one pass over at most 16 columns.
// Reset (synchronous, active low) clears the pattern and loads the empty row.
// A stalled result holds; a new transaction is still taken while the input
// register is empty or moves forward in the same cycle.
module dot_star_pattern_matcher_unit #(
    parameter int MAX_PATTERN = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] text_char
    input  wire logic        s_axis_tuser,   // [0] mode
    // output stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [0] prefix_matches, [7:1] zero
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready
);

    logic [63:0]                r_pat_low;
    logic [63:0]                r_pat_high;
    logic [dspm_pkg::LEN_W-1:0] r_pat_len;

    logic                       r_in_valid;
    dspm_pkg::t_item            r_item;
    logic                       r_out_valid;
    logic                       r_out_match;
    logic [MAX_PATTERN:0]       r_row;

    logic [MAX_PATTERN:0]       n_row;
    logic                       n_match;
    logic                       w_advance;
    logic                       w_cfg_wr;

    // Configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_low  <= '0;
            r_pat_high <= '0;
            r_pat_len  <= '0;
        end else if (w_cfg_wr) begin
            unique case (paddr[4:3])
                dspm_pkg::REG_PAT_LOW:  r_pat_low  <= pwdata;
                dspm_pkg::REG_PAT_HIGH: r_pat_high <= pwdata;
                dspm_pkg::REG_PAT_LEN:  r_pat_len  <= pwdata[dspm_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (paddr[4:3])
            dspm_pkg::REG_PAT_LOW:  prdata = r_pat_low;
            dspm_pkg::REG_PAT_HIGH: prdata = r_pat_high;
            dspm_pkg::REG_PAT_LEN:  prdata = {{(64-dspm_pkg::LEN_W){1'b0}}, r_pat_len};
            default:                prdata = '0;
        endcase
    end

    // Move the held transaction forward when the result slot frees up
    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || !r_out_valid || m_axis_tready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_item.mode      <= s_axis_tuser;
            r_item.text_char <= s_axis_tdata;
        end
    end

    // Next match row
    dspm_row_next #(
        .MAX_PATTERN(MAX_PATTERN)
    ) u_row_next (
        .i_row      (r_row),
        .i_item     (r_item),
        .i_pat_low  (r_pat_low),
        .i_pat_high (r_pat_high),
        .i_pat_len  (r_pat_len),
        .o_row      (n_row),
        .o_match    (n_match)
    );

    // Row state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row       <= {{MAX_PATTERN{1'b0}}, 1'b1};
            r_out_valid <= 1'b0;
        end else begin
            if (w_advance) begin
                r_row <= n_row;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_match <= n_match;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'b0, r_out_match};

endmodule

`default_nettype wire

[rtl/dspm_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module dspm_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [7:0]  m_axis_tdata,
    input wire logic        pready
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // Keep the padding bits of a result clear
    a_out_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[7:1] == 7'b0)
        else $error("result padding not zero");

    // Take input whenever no result is pending
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    // Output never goes valid straight out of reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // Complete every configuration access at once
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("configuration access stalled");

endmodule

bind dot_star_pattern_matcher_unit dspm_checker u_dspm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .pready        (pready)
);

`default_nettype wire
